// ----- rtl/ms_pkg.sv -----
package ms_pkg;

   localparam int VALUE_W       = 32;
   localparam int DEPTH_DEFAULT = 8;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);

   // One classified transaction on its way from the front to the chain
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      keep;
      logic                      last;
      logic                      dropped;
   } ms_entry_type;

endpackage

// ----- rtl/ms_req_if.sv -----
interface ms_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [ms_pkg::VALUE_W-1:0] value;
   logic                              is_last;

   modport source (output valid, output value, output is_last, input ready);
   modport sink   (input valid, input value, input is_last, output ready);
endinterface

// ----- rtl/ms_rsp_if.sv -----
interface ms_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [ms_pkg::VALUE_W-1:0] sorted_value;
   logic                              end_of_run;
   logic                              dropped;

   modport source (output valid, output sorted_value, output end_of_run, output dropped,
                   input ready);
   modport sink   (input valid, input sorted_value, input end_of_run, input dropped,
                   output ready);
endinterface

// ----- rtl/ms_front.sv -----
module ms_front #(
   parameter int DEPTH = ms_pkg::DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   ms_req_if.sink               req_chan,
   input  logic                 queue_full,
   output logic                 push_valid,
   output ms_pkg::ms_entry_type push_entry
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic             full;
   logic             accept;

   assign full           = (count_ff == CNT_W'(DEPTH));
   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && !queue_full;

   assign push_valid         = accept;
   assign push_entry.value   = req_chan.value;
   assign push_entry.keep    = !full;
   assign push_entry.last    = req_chan.is_last;
   assign push_entry.dropped = ovf_ff || full;

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (accept) begin
         if (req_chan.is_last) begin
            // close the set
            count_in = '0;
            ovf_in   = 1'b0;
         end else if (full) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

// ----- rtl/ms_queue.sv -----
module ms_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  ms_pkg::ms_entry_type push_entry,
   output logic                 full,
   output logic                 pop_avail,
   input  logic                 pop,
   output ms_pkg::ms_entry_type pop_entry
);

   localparam int PW = ms_pkg::QUEUE_PTR_W;

   ms_pkg::ms_entry_type entry_ff [ms_pkg::QUEUE_DEPTH];
   logic [PW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [PW:0]          fill_ff, fill_in;
   logic                 do_pop;

   assign full      = (fill_ff == (PW+1)'(ms_pkg::QUEUE_DEPTH));
   assign pop_avail = (fill_ff != '0);
   assign pop_entry = entry_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_avail;

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push_valid && !do_pop) begin
         fill_in = fill_ff + (PW+1)'(1);
      end else if (do_pop && !push_valid) begin
         fill_in = fill_ff - (PW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ----- rtl/ms_chain.sv -----
module ms_chain #(
   parameter int DEPTH = ms_pkg::DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_avail,
   input  ms_pkg::ms_entry_type pop_entry,
   output logic                 pop,
   ms_rsp_if.source             rsp_chan
);

   localparam int W = ms_pkg::VALUE_W;

   logic signed [W-1:0] cell_ff  [DEPTH];
   logic signed [W-1:0] cell_in  [DEPTH];
   logic [DEPTH-1:0]    valid_ff, valid_in;
   logic [DEPTH-1:0]    above;
   logic                drain_ff, drain_in;
   logic                drop_ff, drop_in;
   logic                out_valid_ff, out_valid_in;
   logic signed [W-1:0] out_value_ff;
   logic                out_end_ff;
   logic                out_drop_ff;
   logic                insert;
   logic                shift;

   assign pop    = pop_avail && !drain_ff;
   assign insert = pop && pop_entry.keep;
   assign shift  = drain_ff && (!out_valid_ff || rsp_chan.ready);

   // a cell lies above the new value when it is empty or holds a larger one
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         above[i] = !valid_ff[i] || (pop_entry.value < cell_ff[i]);
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_in[i]  = cell_ff[i];
         valid_in[i] = valid_ff[i];
         if (shift) begin
            if (i == DEPTH - 1) begin
               valid_in[i] = 1'b0;
            end else begin
               cell_in[i]  = cell_ff[i+1];
               valid_in[i] = valid_ff[i+1];
            end
         end else if (insert) begin
            if (i == 0) begin
               valid_in[i] = 1'b1;
               if (above[i]) begin
                  cell_in[i] = pop_entry.value;
               end
            end else begin
               valid_in[i] = valid_ff[i] || valid_ff[i-1];
               if (above[i]) begin
                  cell_in[i] = above[i-1] ? cell_ff[i-1] : pop_entry.value;
               end
            end
         end
      end
   end

   always_comb begin
      drain_in = drain_ff;
      drop_in  = drop_ff;
      if (pop && pop_entry.last) begin
         drain_in = 1'b1;
         drop_in  = pop_entry.dropped;
      end else if (shift && !valid_ff[1]) begin
         // smallest remaining cell was the final one
         drain_in = 1'b0;
      end
      if (shift) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_ff[i] <= cell_in[i];
      end
      drop_ff <= drop_in;
      if (shift) begin
         out_value_ff <= cell_ff[0];
         out_end_ff   <= !valid_ff[1];
         out_drop_ff  <= drop_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         drain_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         drain_ff     <= drain_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.sorted_value = out_value_ff;
   assign rsp_chan.end_of_run   = out_end_ff;
   assign rsp_chan.dropped      = out_drop_ff;

endmodule

// ----- rtl/merge_sorter.sv -----
// Sorts a set of signed 32-bit values into ascending order.
// req_chan carries one value per transaction; is_last closes the set.
// rsp_chan returns the stored values smallest first, end_of_run on the
// largest, dropped on every result of a set that lost values beyond DEPTH.
// Loading: one transaction per cycle while the queue is not full. The front
// counts and classifies each value, a four-entry queue holds it, and the
// insertion chain (DEPTH cells, one compare per cell) places it.
// Draining: one result per cycle while rsp_chan is ready, shifted out of the
// bottom of the chain into the output register. The first result of a set
// follows the marked transaction through the queue, the drain flag and the
// output register, later if the chain is still draining an earlier set.
// While the chain drains, the next set loads into the queue until it fills,
// then req_chan.ready falls.
// A stall on rsp_chan holds the output register and the chain; the queue
// then fills and back-pressures req_chan.
// Reset (synchronous) empties the queue and the chain and clears the count.
module merge_sorter #(
   parameter int DEPTH = ms_pkg::DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   ms_req_if.sink    req_chan,
   ms_rsp_if.source  rsp_chan
);

   logic                 push_valid;
   ms_pkg::ms_entry_type push_entry;
   logic                 queue_full;
   logic                 pop_avail;
   logic                 pop;
   ms_pkg::ms_entry_type pop_entry;

   ms_front #(.DEPTH(DEPTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   ms_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop_avail  (pop_avail),
      .pop        (pop),
      .pop_entry  (pop_entry)
   );

   ms_chain #(.DEPTH(DEPTH)) u_chain (
      .clock     (clock),
      .reset     (reset),
      .pop_avail (pop_avail),
      .pop_entry (pop_entry),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ----- rtl/ms_checker.sv -----
module ms_checker #(
   parameter int DEPTH = ms_pkg::DEPTH_DEFAULT
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              req_is_last,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [ms_pkg::VALUE_W-1:0] rsp_sorted_value,
   input logic                              rsp_end_of_run,
   input logic                              rsp_dropped
);

   localparam int RUN_W = $clog2(DEPTH + 1) + 1;

   logic                              req_acc;
   logic                              rsp_acc;
   logic [3:0]                        marks_ff;
   logic [RUN_W-1:0]                  run_ff;
   logic                              in_run_ff;
   logic                              drop_ff;
   logic signed [ms_pkg::VALUE_W-1:0] prev_value_ff;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         marks_ff      <= '0;
         run_ff        <= '0;
         in_run_ff     <= 1'b0;
         drop_ff       <= 1'b0;
         prev_value_ff <= '0;
      end else begin
         marks_ff <= marks_ff + 4'(req_acc && req_is_last) - 4'(rsp_acc && rsp_end_of_run);
         if (rsp_acc) begin
            run_ff        <= rsp_end_of_run ? '0 : run_ff + RUN_W'(1);
            in_run_ff     <= !rsp_end_of_run;
            drop_ff       <= rsp_dropped;
            prev_value_ff <= rsp_sorted_value;
         end
      end
   end

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sorted_value)
         && $stable(rsp_end_of_run) && $stable(rsp_dropped))
      else $error("rsp transaction changed while stalled");

   a_rsp_after_mark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> marks_ff != '0)
      else $error("result without a closed set");

   a_run_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> run_ff < RUN_W'(DEPTH))
      else $error("set longer than DEPTH");

   a_drop_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && in_run_ff |-> rsp_dropped == drop_ff)
      else $error("dropped flag changed within a set");

   a_ascending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && in_run_ff |-> rsp_sorted_value >= prev_value_ff)
      else $error("results of a set out of ascending order");

endmodule

bind merge_sorter ms_checker #(.DEPTH(DEPTH)) u_ms_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_is_last      (req_chan.is_last),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_sorted_value (rsp_chan.sorted_value),
   .rsp_end_of_run   (rsp_chan.end_of_run),
   .rsp_dropped      (rsp_chan.dropped)
);
